// ----- rtl/xkfd_pkg.sv -----
package xkfd_pkg;

    // Frame layout: positions counted from byte 0
    localparam logic [4:0] FRAME_LAST  = 5'd18;
    localparam logic [4:0] PRICE_FIRST = 5'd2;
    localparam logic [4:0] PRICE_LAST  = 5'd5;
    localparam logic [4:0] ITEM_FIRST  = 5'd6;
    localparam logic [4:0] ITEM_LAST   = 5'd7;
    localparam logic [4:0] STAMP_FIRST = 5'd8;
    localparam logic [4:0] STAMP_LAST  = 5'd11;

    localparam int KEY_BYTES = 18;

    // Window reset value in seconds
    localparam logic [7:0] WINDOW_RESET = 8'd8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_MID  = 2'd1,
        REG_KEY_HIGH = 2'd2,
        REG_WINDOW   = 2'd3
    } reg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SUM_ERR = 2'd1,
        STATUS_STALE   = 2'd2
    } status_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [8*KEY_BYTES-1:0] key;
        logic [7:0]             window;
    } cfg_t;

endpackage

// ----- rtl/xor_keyed_frame_decoder.sv -----
// Channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------
// frame    | frame_valid / frame_stall | frame_byte, frame_start, now_seconds
// result   | result_valid/result_stall | frame_status, wire_price, item_index
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One frame byte is taken every cycle unless frame_stall holds it; a frame is
// 19 bytes long and its result shows in the result register in the cycle after the last byte.
// Decrypt, sum, capture and the timestamp compare all sit in the same cycle.
// Reset clears position, sums and captures; keys reset to 0, window to 8.
// frame_stall rises only while a result is held and the next byte would be
// the last byte of a frame; cfg_ready is always high.
module xor_keyed_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_start,
    input  logic signed [31:0] now_seconds,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  frame_status,
    output logic [31:0] wire_price,
    output logic [15:0] item_index,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    xkfd_pkg::cfg_t cfg;

    logic [4:0]  pos_reg;
    logic [7:0]  sum_reg;
    logic [31:0] price_reg;
    logic [15:0] item_reg;
    logic [31:0] stamp_reg;

    logic                res_valid_reg;
    xkfd_pkg::status_t   res_status_reg;
    logic [31:0]         res_price_reg;
    logic [15:0]         res_item_reg;

    logic        frame_acc;
    logic        result_acc;
    logic [4:0]  pos_cur;
    logic        first_byte;
    logic        last_byte;
    logic [4:0]  key_idx;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [7:0]  sum_base;
    logic [31:0] price_base;
    logic [15:0] item_base;
    logic [31:0] stamp_base;
    logic [32:0] diff;
    logic [32:0] distance;
    logic        sum_bad;
    logic        stale;

    xkfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Hold bytes only when a last byte could land on a held result
    assign frame_stall = res_valid_reg && result_stall && (pos_reg == xkfd_pkg::FRAME_LAST);
    assign frame_acc   = frame_valid && !frame_stall;
    assign result_acc  = res_valid_reg && !result_stall;

    // Restart position on a start mark
    assign pos_cur    = frame_start ? 5'd0 : pos_reg;
    assign first_byte = (pos_cur == 5'd0);
    assign last_byte  = (pos_cur == xkfd_pkg::FRAME_LAST);
    assign key_idx    = pos_cur - 5'd1;

    // Pick the key byte for this position
    always_comb
    begin
        key_byte = 8'h00;
        for (int k = 0; k < xkfd_pkg::KEY_BYTES; k++)
        begin
            if (key_idx == 5'(k))
            begin
                key_byte = cfg.key[k*8 +: 8];
            end
        end
    end

    // Decrypt; byte 0 passes in clear and clears the captures
    assign plain      = first_byte ? frame_byte : (frame_byte ^ key_byte);
    assign sum_base   = first_byte ? 8'h00  : sum_reg;
    assign price_base = first_byte ? 32'h0  : price_reg;
    assign item_base  = first_byte ? 16'h0  : item_reg;
    assign stamp_base = first_byte ? 32'h0  : stamp_reg;

    // Check the checksum and the timestamp distance
    assign sum_bad  = (plain != sum_reg);
    assign diff     = {now_seconds[31], now_seconds} - {stamp_reg[31], stamp_reg};
    assign distance = diff[32] ? (~diff + 33'd1) : diff;
    assign stale    = (distance > {25'd0, cfg.window});

    // Advance the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            price_reg <= '0;
            item_reg  <= '0;
            stamp_reg <= '0;
        end
        else if (frame_acc)
        begin
            if (last_byte)
            begin
                pos_reg <= 5'd0;
            end
            else
            begin
                pos_reg <= pos_cur + 5'd1;
                sum_reg <= sum_base + plain;
                price_reg <= price_base;
                item_reg  <= item_base;
                stamp_reg <= stamp_base;
                if (pos_cur >= xkfd_pkg::PRICE_FIRST && pos_cur <= xkfd_pkg::PRICE_LAST)
                begin
                    price_reg <= {price_base[23:0], plain};
                end
                else if (pos_cur >= xkfd_pkg::ITEM_FIRST && pos_cur <= xkfd_pkg::ITEM_LAST)
                begin
                    item_reg <= {item_base[7:0], plain};
                end
                else if (pos_cur >= xkfd_pkg::STAMP_FIRST &&
                         pos_cur <= xkfd_pkg::STAMP_LAST)
                begin
                    stamp_reg <= {stamp_base[23:0], plain};
                end
            end
        end
    end

    // Load the result on the last byte, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (frame_acc && last_byte)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_acc)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_acc && last_byte)
        begin
            if (sum_bad)
            begin
                res_status_reg <= xkfd_pkg::STATUS_SUM_ERR;
                res_price_reg  <= '0;
                res_item_reg   <= '0;
            end
            else if (stale)
            begin
                res_status_reg <= xkfd_pkg::STATUS_STALE;
                res_price_reg  <= '0;
                res_item_reg   <= '0;
            end
            else
            begin
                res_status_reg <= xkfd_pkg::STATUS_OK;
                res_price_reg  <= price_reg;
                res_item_reg   <= item_reg;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign frame_status = res_status_reg;
    assign wire_price   = res_price_reg;
    assign item_index   = res_item_reg;

    // A last byte always yields a result beat
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_acc && last_byte |=> result_valid)
        else $error("last byte did not load a result");

    // Position never runs past the last byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= xkfd_pkg::FRAME_LAST)
        else $error("byte position out of range");

    // Rejected frames carry no price or item
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (frame_status != xkfd_pkg::STATUS_OK)
        |-> (wire_price == 32'h0) && (item_index == 16'h0))
        else $error("rejected frame carries payload");

    // A start mark makes the next position one
    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        frame_acc && frame_start |=> pos_reg == 5'd1)
        else $error("start mark did not restart the frame");

endmodule

// ----- rtl/xkfd_cfg_regs.sv -----
module xkfd_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    output xkfd_pkg::cfg_t cfg
);

    logic [63:0] key_low_reg;
    logic [63:0] key_mid_reg;
    logic [15:0] key_high_reg;
    logic [7:0]  window_reg;

    // Take every write beat at once
    assign cfg_ready = 1'b1;

    // Decode the index and load the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_high_reg <= '0;
            window_reg   <= xkfd_pkg::WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (xkfd_pkg::reg_index_t'(cfg_index))
                xkfd_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                xkfd_pkg::REG_KEY_MID:  key_mid_reg  <= cfg_data;
                xkfd_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data[15:0];
                xkfd_pkg::REG_WINDOW:   window_reg   <= cfg_data[7:0];
                default:                window_reg   <= window_reg;
            endcase
        end
    end

    assign cfg.key    = {key_high_reg, key_mid_reg, key_low_reg};
    assign cfg.window = window_reg;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Frame layout as seen by the checker
    localparam int LAST_POS    = 18;
    localparam int PRICE_START = 2;
    localparam int PRICE_END   = 5;
    localparam int ITEM_START  = 6;
    localparam int ITEM_END    = 7;
    localparam int STAMP_START = 8;
    localparam int STAMP_END   = 11;
    localparam int IDLE_PCT    = 34;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [7:0]         data;
        logic               mark;
        logic signed [31:0] now;
    } frame_beat_t;

    typedef struct packed {
        xkfd_pkg::status_t status;
        logic [31:0]       price;
        logic [15:0]       item;
    } frame_result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 frame_valid  = 1'b0;
    logic                 frame_stall;
    logic [7:0]           frame_byte   = '0;
    logic                 frame_start  = 1'b0;
    logic signed [31:0]   now_seconds  = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [1:0]           frame_status;
    logic [31:0]          wire_price;
    logic [15:0]          item_index;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    xkfd_pkg::reg_index_t cfg_index    = xkfd_pkg::REG_KEY_LOW;
    logic [63:0]          cfg_data     = '0;

    // Mirror of the configuration
    logic [8*18-1:0] key_bits     = '0;
    logic [7:0]      window_limit = 8'd8;

    // Decoder state as predicted
    int          frame_pos = 0;
    logic [7:0]  frame_sum = '0;
    logic [31:0] price_acc = '0;
    logic [15:0] item_acc  = '0;
    logic [31:0] stamp_acc = '0;

    frame_beat_t   beats_to_send[$];
    frame_result_t results_due[$];
    frame_beat_t   next_beat;
    frame_result_t due_now;

    logic calm         = 1'b0;
    int   errors       = 0;
    int   results_seen = 0;
    int   hold_left    = 0;
    int   held_at      = -1;

    xor_keyed_frame_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_byte   (frame_byte),
        .frame_start  (frame_start),
        .now_seconds  (now_seconds),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .frame_status (frame_status),
        .wire_price   (wire_price),
        .item_index   (item_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Advance the predicted decoder by one accepted byte
    task automatic decode_beat(input logic [7:0] raw, input logic mark,
                               input logic signed [31:0] now);
        logic [7:0]    plain;
        longint        gap;
        frame_result_t res;
        if (mark)
            frame_pos = 0;
        if (frame_pos == 0)
        begin
            frame_sum = '0;
            price_acc = '0;
            item_acc  = '0;
            stamp_acc = '0;
            plain     = raw;
        end
        else
        begin
            plain = raw ^ key_bits[8*(frame_pos-1) +: 8];
        end
        if (frame_pos < LAST_POS)
        begin
            frame_sum = frame_sum + plain;
            if (frame_pos >= PRICE_START && frame_pos <= PRICE_END)
                price_acc = {price_acc[23:0], plain};
            else if (frame_pos >= ITEM_START && frame_pos <= ITEM_END)
                item_acc = {item_acc[7:0], plain};
            else if (frame_pos >= STAMP_START && frame_pos <= STAMP_END)
                stamp_acc = {stamp_acc[23:0], plain};
            frame_pos = frame_pos + 1;
        end
        else
        begin
            frame_pos = 0;
            res = '{status: xkfd_pkg::STATUS_OK, price: price_acc, item: item_acc};
            if (plain != frame_sum)
            begin
                res = '{status: xkfd_pkg::STATUS_SUM_ERR, price: '0, item: '0};
            end
            else
            begin
                gap = longint'(now) - longint'($signed(stamp_acc));
                if (gap < 0)
                    gap = -gap;
                if (gap > longint'(window_limit))
                    res = '{status: xkfd_pkg::STATUS_STALE, price: '0, item: '0};
            end
            results_due.push_back(res);
        end
    endtask

    // Build one frame, encrypt it with the current key and queue its first cut bytes
    task automatic push_frame(input logic [7:0] head, input logic [31:0] price,
                              input logic [15:0] item, input logic [31:0] stamp,
                              input logic [31:0] now_last, input bit corrupt,
                              input bit mark, input int cut);
        logic [7:0]  plain [19];
        logic [7:0]  sum;
        frame_beat_t b;
        int          i;
        plain[0] = head;
        plain[1] = 8'($urandom);
        for (i = 0; i < 4; i++)
        begin
            plain[PRICE_START+i] = price[31-8*i -: 8];
            plain[STAMP_START+i] = stamp[31-8*i -: 8];
        end
        plain[ITEM_START] = item[15:8];
        plain[ITEM_END]   = item[7:0];
        for (i = STAMP_END + 1; i < LAST_POS; i++)
            plain[i] = 8'($urandom);
        sum = '0;
        for (i = 0; i < LAST_POS; i++)
            sum = sum + plain[i];
        plain[LAST_POS] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
        for (i = 0; i < cut; i++)
        begin
            b.data = (i == 0) ? plain[0] : plain[i] ^ key_bits[8*(i-1) +: 8];
            b.mark = (i == 0) ? mark : 1'b0;
            b.now  = (i == LAST_POS) ? now_last : $urandom;
            beats_to_send.push_back(b);
        end
    endtask

    // Mostly well-formed frames, some corrupt, cut short, unmarked or noise
    task automatic push_random_frame();
        int          r;
        int          n;
        int          span;
        logic [31:0] stamp;
        logic [31:0] now_last;
        frame_beat_t b;
        r = $urandom_range(0, 99);
        if (r >= 93)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
            begin
                b.data = 8'($urandom);
                b.mark = ($urandom_range(0, 3) == 0);
                b.now  = $urandom;
                beats_to_send.push_back(b);
            end
            return;
        end
        case ($urandom_range(0, 9))
            0:       stamp = 32'h7FFF_FFFF;
            1:       stamp = 32'h8000_0000;
            2:       stamp = 32'h0000_0000;
            default: stamp = $urandom;
        endcase
        span = int'(window_limit) + 3;
        case ($urandom_range(0, 9))
            0:       now_last = $urandom;
            1:       now_last = stamp + 32'(window_limit) + 32'd1;
            2:       now_last = stamp - 32'(window_limit);
            3:       now_last = stamp - 32'(window_limit) - 32'd1;
            default: now_last = stamp + 32'($urandom_range(0, 2 * span)) - 32'(span);
        endcase
        push_frame(8'($urandom), $urandom, 16'($urandom), stamp, now_last,
                   r >= 70 && r < 80, !(r >= 88 && r < 93),
                   (r >= 80 && r < 88) ? $urandom_range(1, LAST_POS) : LAST_POS + 1);
    endtask

    // Write one register; the caller lowers cfg_valid after its last write
    task automatic write_reg(input xkfd_pkg::reg_index_t idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            xkfd_pkg::REG_KEY_LOW:  key_bits[63:0]    = data;
            xkfd_pkg::REG_KEY_MID:  key_bits[127:64]  = data;
            xkfd_pkg::REG_KEY_HIGH: key_bits[143:128] = data[15:0];
            xkfd_pkg::REG_WINDOW:   window_limit      = data[7:0];
            default:                ;
        endcase
    endtask

    // Wait until every byte is taken and every result has come back
    task automatic drain();
        do
            @(negedge clk);
        while (beats_to_send.size() != 0 || frame_valid || results_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Frame driver: hold a stalled beat, advance on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
                decode_beat(frame_byte, frame_start, now_seconds);
            if (!frame_valid || !frame_stall)
            begin
                if (beats_to_send.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_beat = beats_to_send.pop_front();
                    frame_valid <= 1'b1;
                    frame_byte  <= next_beat.data;
                    frame_start <= next_beat.mark;
                    now_seconds <= next_beat.now;
                end
                else
                begin
                    frame_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each beat, stall at random or for a long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: frame_status %0d", frame_status);
                    errors++;
                end
                else
                begin
                    due_now = results_due.pop_front();
                    if (frame_status !== due_now.status)
                    begin
                        $error("frame_status: expected %0d, got %0d",
                               due_now.status, frame_status);
                        errors++;
                    end
                    if (wire_price !== due_now.price)
                    begin
                        $error("wire_price: expected %h, got %h", due_now.price, wire_price);
                        errors++;
                    end
                    if (item_index !== due_now.item)
                    begin
                        $error("item_index: expected %h, got %h", due_now.item, item_index);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (results_seen % 25 == 12 && results_seen != held_at)
            begin
                hold_left = LONG_HOLD;
                held_at   = results_seen;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Stimulus and phase control
    initial
    begin
        int          ph;
        logic [63:0] w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset configuration
        push_frame(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd100, 32'd108, 0, 1, 19);
        push_frame(8'h00, 32'h0000_0000, 16'h0000, 32'd100, 32'd91, 0, 0, 19);
        push_frame(8'h5A, 32'h1234_5678, 16'hABCD, 32'd7, 32'd7, 0, 1, 7);
        push_frame(8'hA5, 32'h8765_4321, 16'h0102, 32'd7, 32'd7, 1, 1, 19);
        push_frame(8'h80, 32'h0000_0001, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 19);
        push_frame(8'h01, 32'h8000_0000, 16'h0001, 32'h8000_0000, 32'h8000_0000, 0, 1, 19);
        push_frame(8'h7F, 32'h0F0F_0F0F, 16'hF0F0, -32'sd5, 32'd3, 0, 0, 19);
        drain();

        // Random phases, each under a fresh configuration
        for (ph = 0; ph < 6; ph++)
        begin
            @(posedge clk);
            w = {$urandom, $urandom};
            if (ph == 0)
                w[7:0] = 8'h00;
            else if (ph == 1)
                w[7:0] = 8'hFF;
            write_reg(xkfd_pkg::REG_WINDOW, w);
            if (ph == 0)
            begin
                write_reg(xkfd_pkg::REG_KEY_LOW, '1);
                write_reg(xkfd_pkg::REG_KEY_MID, '1);
                write_reg(xkfd_pkg::REG_KEY_HIGH, '1);
            end
            else if (ph == 4)
            begin
                write_reg(xkfd_pkg::REG_KEY_LOW, '0);
                write_reg(xkfd_pkg::REG_KEY_MID, '0);
                write_reg(xkfd_pkg::REG_KEY_HIGH, {$urandom, 16'h0000});
            end
            else
            begin
                write_reg(xkfd_pkg::REG_KEY_HIGH, {$urandom, $urandom});
                write_reg(xkfd_pkg::REG_KEY_MID, {$urandom, $urandom});
                write_reg(xkfd_pkg::REG_KEY_LOW, {$urandom, $urandom});
            end
            cfg_valid <= 1'b0;
            calm      <= (ph == 3);
            @(negedge clk);
            repeat (13) push_random_frame();
            drain();
        end

        repeat (10) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/xkfd_pkg.sv
rtl/xkfd_cfg_regs.sv
rtl/xor_keyed_frame_decoder.sv
tb/tb_top.sv
